FILE: hdl/icr_pkg.sv
// Package for the 32-source set/clear interrupt controller.
// Holds the source count, the register selectors, the operation codes and the state type.
// No dependencies.
package icr_pkg;

    localparam int NUM_SOURCES = 32;
    localparam int REG_WIDTH   = 32;
    localparam int SRC_N       = (NUM_SOURCES >= REG_WIDTH) ? REG_WIDTH : NUM_SOURCES;
    localparam logic [REG_WIDTH-1:0] SRC_MASK =
        REG_WIDTH'((65'd1 << SRC_N) - 65'd1);

    localparam int FUNC_W = 2;
    localparam int SEL_W  = 4;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_READ   = 2'd0,
        FUNC_SET    = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_SAMPLE = 2'd3
    } t_func;

    localparam logic [SEL_W-1:0] SEL_CFG0    = 4'd0;
    localparam logic [SEL_W-1:0] SEL_CFG1    = 4'd1;
    localparam logic [SEL_W-1:0] SEL_CFG2    = 4'd2;
    localparam logic [SEL_W-1:0] SEL_ASSIGN  = 4'd3;
    localparam logic [SEL_W-1:0] SEL_SOURCE  = 4'd4;
    localparam logic [SEL_W-1:0] SEL_MASK    = 4'd5;
    localparam logic [SEL_W-1:0] SEL_WAKE    = 4'd6;
    localparam logic [SEL_W-1:0] SEL_RISING  = 4'd7;
    localparam logic [SEL_W-1:0] SEL_FALLING = 4'd8;
    localparam logic [SEL_W-1:0] SEL_REQ0    = 4'd9;
    localparam logic [SEL_W-1:0] SEL_REQ1    = 4'd10;

    typedef struct packed {
        logic [REG_WIDTH-1:0] cfg0;
        logic [REG_WIDTH-1:0] cfg1;
        logic [REG_WIDTH-1:0] cfg2;
        logic [REG_WIDTH-1:0] assign_bits;
        logic [REG_WIDTH-1:0] source_bits;
        logic [REG_WIDTH-1:0] mask_bits;
        logic [REG_WIDTH-1:0] wake_bits;
        logic [REG_WIDTH-1:0] rising_latch;
        logic [REG_WIDTH-1:0] falling_latch;
        logic [REG_WIDTH-1:0] prev_levels;
    } t_regs;

    typedef struct packed {
        logic [REG_WIDTH-1:0] is_rise;
        logic [REG_WIDTH-1:0] is_fall;
        logic [REG_WIDTH-1:0] active;
    } t_act;

endpackage

FILE: hdl/icr_active.sv
// Per-source trigger decode and activity vector of the interrupt controller.
// Depends on icr_pkg.
module icr_active (
    input  icr_pkg::t_regs i_regs,
    output icr_pkg::t_act  o_act
);

    logic [icr_pkg::REG_WIDTH-1:0] code_001;
    logic [icr_pkg::REG_WIDTH-1:0] code_010;
    logic [icr_pkg::REG_WIDTH-1:0] code_101;
    logic [icr_pkg::REG_WIDTH-1:0] code_110;

    always_comb begin
        code_001 = ~i_regs.cfg2 & ~i_regs.cfg1 &  i_regs.cfg0 & icr_pkg::SRC_MASK;
        code_010 = ~i_regs.cfg2 &  i_regs.cfg1 & ~i_regs.cfg0 & icr_pkg::SRC_MASK;
        code_101 =  i_regs.cfg2 & ~i_regs.cfg1 &  i_regs.cfg0 & icr_pkg::SRC_MASK;
        code_110 =  i_regs.cfg2 &  i_regs.cfg1 & ~i_regs.cfg0 & icr_pkg::SRC_MASK;
        o_act.is_rise = code_001;
        o_act.is_fall = code_010;
        o_act.active  = ((code_001 & i_regs.rising_latch)
                       | (code_010 & i_regs.falling_latch)
                       | (code_101 & i_regs.prev_levels)
                       | (code_110 & ~i_regs.prev_levels))
                       & i_regs.mask_bits & icr_pkg::SRC_MASK;
    end

endmodule

FILE: hdl/interrupt_controller_regs_unit.sv
// 32-source set/clear interrupt controller: register file, sampling and request outputs.
// Depends on icr_pkg and icr_active.
//
// Usage: each item on the slave stream is one bus operation (tuser = func: read,
// write-one-to-set, write-one-to-clear) or one sample of the 32 source lines.
// The master stream returns one item per input item: the read data (zero unless
// the item was a read) and the two request lines as they stand after the item.
// o_m_axis_tvalid rises in the cycle after input acceptance. Throughput is one item
// per cycle while the receiver does not stall: the state update and result are short
// parallel bitwise logic between the state registers and the result register.
// The single result register holds while the receiver stalls; o_s_axis_tready drops
// only while it is full and not being taken, so no item is lost.
// Synchronous reset (i_rst_n low) clears the state registers, including the mask, so
// every source is disabled, and empties the result register.
module interrupt_controller_regs_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [3:0] reg_select, [35:4] write_data, [67:36] line_levels, [71:68] zero
    input  logic [icr_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] func
    input  logic [icr_pkg::FUNC_W-1:0]     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [31:0] read_data, [32] request0_line, [33] request1_line, [39:34] zero
    output logic [icr_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    icr_pkg::t_regs r_regs;
    icr_pkg::t_regs n_regs;
    icr_pkg::t_act  act_cur;
    icr_pkg::t_act  act_nxt;

    logic                          accept;
    icr_pkg::t_func                func;
    logic [icr_pkg::SEL_W-1:0]     sel;
    logic [icr_pkg::REG_WIDTH-1:0] wdata;
    logic [icr_pkg::REG_WIDTH-1:0] lines;
    logic [icr_pkg::REG_WIDTH-1:0] n_rd;
    logic                          n_req0;
    logic                          n_req1;

    logic                          r_valid;
    logic [icr_pkg::REG_WIDTH-1:0] r_rd;
    logic                          r_req0;
    logic                          r_req1;

    function automatic logic [icr_pkg::REG_WIDTH-1:0] upd(
        input logic [icr_pkg::REG_WIDTH-1:0] old,
        input logic [icr_pkg::REG_WIDTH-1:0] d,
        input icr_pkg::t_func                f
    );
        logic [icr_pkg::REG_WIDTH-1:0] res;
        res = old;
        if (f == icr_pkg::FUNC_SET) begin
            res = old | d;
        end else if (f == icr_pkg::FUNC_CLEAR) begin
            res = old & ~d;
        end
        return res;
    endfunction

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_valid || i_m_axis_tready;

    assign func  = icr_pkg::t_func'(i_s_axis_tuser);
    assign sel   = i_s_axis_tdata[3:0];
    assign wdata = i_s_axis_tdata[35:4] & icr_pkg::SRC_MASK;
    assign lines = i_s_axis_tdata[67:36] & icr_pkg::SRC_MASK;

    icr_active u_act_cur (
        .i_regs (r_regs),
        .o_act  (act_cur)
    );

    icr_active u_act_nxt (
        .i_regs (n_regs),
        .o_act  (act_nxt)
    );

    always_comb begin
        n_regs = r_regs;
        n_rd   = '0;
        case (func)
            icr_pkg::FUNC_READ: begin
                case (sel)
                    icr_pkg::SEL_CFG0:    n_rd = r_regs.cfg0;
                    icr_pkg::SEL_CFG1:    n_rd = r_regs.cfg1;
                    icr_pkg::SEL_CFG2:    n_rd = r_regs.cfg2;
                    icr_pkg::SEL_ASSIGN:  n_rd = r_regs.assign_bits;
                    icr_pkg::SEL_SOURCE:  n_rd = r_regs.source_bits;
                    icr_pkg::SEL_MASK:    n_rd = r_regs.mask_bits;
                    icr_pkg::SEL_WAKE:    n_rd = r_regs.wake_bits;
                    icr_pkg::SEL_RISING:  n_rd = r_regs.rising_latch;
                    icr_pkg::SEL_FALLING: n_rd = r_regs.falling_latch;
                    icr_pkg::SEL_REQ0:    n_rd = act_cur.active & r_regs.assign_bits;
                    icr_pkg::SEL_REQ1:    n_rd = act_cur.active & ~r_regs.assign_bits;
                    default:              n_rd = '0;
                endcase
            end
            icr_pkg::FUNC_SET, icr_pkg::FUNC_CLEAR: begin
                case (sel)
                    icr_pkg::SEL_CFG0:    n_regs.cfg0 = upd(r_regs.cfg0, wdata, func);
                    icr_pkg::SEL_CFG1:    n_regs.cfg1 = upd(r_regs.cfg1, wdata, func);
                    icr_pkg::SEL_CFG2:    n_regs.cfg2 = upd(r_regs.cfg2, wdata, func);
                    icr_pkg::SEL_ASSIGN:
                        n_regs.assign_bits = upd(r_regs.assign_bits, wdata, func);
                    icr_pkg::SEL_SOURCE:
                        n_regs.source_bits = upd(r_regs.source_bits, wdata, func);
                    icr_pkg::SEL_MASK:
                        n_regs.mask_bits = upd(r_regs.mask_bits, wdata, func);
                    icr_pkg::SEL_WAKE:
                        n_regs.wake_bits = upd(r_regs.wake_bits, wdata, func);
                    icr_pkg::SEL_RISING:
                        n_regs.rising_latch = upd(r_regs.rising_latch, wdata, func);
                    icr_pkg::SEL_FALLING:
                        n_regs.falling_latch = upd(r_regs.falling_latch, wdata, func);
                    default: n_regs = r_regs;
                endcase
            end
            icr_pkg::FUNC_SAMPLE: begin
                n_regs.rising_latch  = r_regs.rising_latch
                                     | (act_cur.is_rise & ~r_regs.prev_levels & lines);
                n_regs.falling_latch = r_regs.falling_latch
                                     | (act_cur.is_fall & r_regs.prev_levels & ~lines);
                n_regs.prev_levels   = lines;
            end
            default: n_regs = r_regs;
        endcase
        n_rd   = n_rd & icr_pkg::SRC_MASK;
        n_req0 = |(act_nxt.active & n_regs.assign_bits);
        n_req1 = |(act_nxt.active & ~n_regs.assign_bits);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_regs <= n_regs;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd   <= n_rd;
            r_req0 <= n_req0;
            r_req1 <= n_req1;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {6'd0, r_req1, r_req0, r_rd};

endmodule

FILE: hdl/icr_checker.sv
// Port-level checks for the interrupt controller, bound to the top level.
// Depends on icr_pkg and interrupt_controller_regs_unit.
module icr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic [icr_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic [icr_pkg::FUNC_W-1:0]     i_s_axis_tuser,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [icr_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without output stall");

    a_item_yields_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("accepted item gave no result");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser != icr_pkg::FUNC_READ)
        |=> o_m_axis_tdata[31:0] == 32'd0)
        else $error("read data nonzero on a non-read item");

endmodule

bind interrupt_controller_regs_unit icr_checker u_icr_checker (.*);
